FILE: rtl/core/rchfb_pkg.sv
// Shared constants, types and the fixed hop seed table for the RC hop frame builder.
// No dependencies.
package rchfb_pkg;

  localparam int unsigned HOP_DEPTH = 16;
  localparam int unsigned CHAN_NUM  = 8;
  localparam int unsigned CHAN_W    = 12;
  localparam int unsigned BYTE_W    = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_TX_ID  = 2'd0;
  localparam logic [1:0] CFG_BIND   = 2'd1;
  localparam logic [1:0] CFG_CENTER = 2'd2;

  localparam logic [11:0] CENTER_RESET = 12'd1500;

  localparam logic [7:0] HDR_BIND   = 8'hAA;
  localparam logic [7:0] HDR_NORM   = 8'h55;
  localparam logic [7:0] BIND_CHAN  = 8'h01;
  localparam logic [7:0] ODD_OFFSET = 8'h50;
  localparam logic [7:0] ID_ADJ     = 8'h70;
  localparam logic [3:0] ID_HI_MAX  = 4'h9;

  // packet byte positions
  localparam logic [BYTE_W-1:0] BYTE_HDR   = 5'd0;
  localparam logic [BYTE_W-1:0] BYTE_ID3   = 5'd1;
  localparam logic [BYTE_W-1:0] BYTE_ID2   = 5'd2;
  localparam logic [BYTE_W-1:0] BYTE_ID1   = 5'd3;
  localparam logic [BYTE_W-1:0] BYTE_ID0   = 5'd4;
  localparam logic [BYTE_W-1:0] BYTE_WIDTH = 5'd5;
  localparam logic [BYTE_W-1:0] BYTE_WLAST = 5'd20;
  localparam logic [BYTE_W-1:0] BYTE_CHAN  = 5'd21;

  typedef struct packed {
    logic                init_start;
    logic                frame_start;
    logic                build_step;
    logic                out_load;
    logic [BYTE_W-1:0]   byte_idx;
    logic                hop_advance;
  } rchfb_cmd_t;

  typedef struct packed {
    logic build_last;
  } rchfb_stat_t;

  function automatic logic [7:0] seed_byte(input logic [2:0] row, input logic [1:0] col);
    logic [31:0] r;
    unique case (row)
      3'd0: r = 32'h12345678;
      3'd1: r = 32'h18273645;
      3'd2: r = 32'h41823657;
      3'd3: r = 32'h84136572;
      3'd4: r = 32'h87641532;
      3'd5: r = 32'h76841352;
      3'd6: r = 32'h71628435;
      default: r = 32'h71864352;
    endcase
    unique case (col)
      2'd0: return r[31:24];
      2'd1: return r[23:16];
      2'd2: return r[15:8];
      default: return r[7:0];
    endcase
  endfunction

endpackage

FILE: rtl/core/rchfb_ctrl.sv
// Sequencer for the RC hop frame builder: table rebuild walk and byte emission.
// Depends on rchfb_pkg; drives rchfb_dp by command struct.
module rchfb_ctrl
  import rchfb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_kind_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  input  rchfb_stat_t stat_i,
  output rchfb_cmd_t  cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_BUILD, S_EMIT} state_e;

  state_e            state_q, state_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign load        = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.byte_idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d = BYTE_HDR;
          if (in_kind_i) begin
            cmd_o.frame_start = 1'b1;
            state_d = S_EMIT;
          end else begin
            cmd_o.init_start = 1'b1;
            state_d = S_BUILD;
          end
        end
      end
      S_BUILD: begin
        cmd_o.build_step = 1'b1;
        if (stat_i.build_last) state_d = S_IDLE;
      end
      default: begin
        if (load) begin
          cmd_o.out_load = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == BYTE_CHAN) begin
            cmd_o.hop_advance = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
    endcase
    // output register empties on accept unless refilled
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> state_q == S_EMIT)
    else $error("output load outside emit");

  a_frame_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_kind_i |=> state_q == S_EMIT && cnt_q == BYTE_HDR)
    else $error("frame item did not start emission");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> cnt_q <= BYTE_CHAN)
    else $error("byte counter out of range");
`endif

endmodule

FILE: rtl/core/rchfb_dp.sv
// Datapath for the RC hop frame builder: hop table, channel capture, byte mux, output register.
// Depends on rchfb_pkg; commanded by rchfb_ctrl.
module rchfb_dp
  import rchfb_pkg::*;
#(
  parameter int unsigned HopDepth = HOP_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rchfb_cmd_t                cmd_i,
  output rchfb_stat_t               stat_o,
  input  logic [31:0]               tx_id_i,
  input  logic                      bind_i,
  input  logic [11:0]               center_i,
  input  logic signed [CHAN_W-1:0]  chan_i [CHAN_NUM],
  output logic [7:0]                out_byte_o,
  output logic                      out_cw_o,
  output logic                      out_ant_o,
  output logic                      out_last_o
);

  localparam int unsigned IdxW = $clog2(HopDepth);

  logic [7:0]        hop_q [HopDepth];
  logic [IdxW-1:0]   pos_q;
  logic [IdxW-1:0]   bld_q;
  logic [7:0]        adj_q;
  logic [CHAN_W-1:0] ch_q [CHAN_NUM];
  logic [7:0]        out_byte_q;
  logic              out_cw_q, out_ant_q, out_last_q;

  logic [7:0]        adj_d;
  logic [7:0]        seed;
  logic [3:0]        nib;
  logic [7:0]        entry;
  logic [IdxW-1:0]   dst;

  logic [BYTE_W-1:0] widx;
  logic [CHAN_W-1:0] sel, rnd, half;
  logic [15:0]       width;
  logic [7:0]        byte_d;

  // top id byte: pull high nibbles above 9 back by 0x70
  always_comb begin
    adj_d = tx_id_i[31:24];
    if (adj_d[7:4] > ID_HI_MAX) adj_d = adj_d - ID_ADJ;
  end

  // one hop entry per build step
  always_comb begin
    seed  = seed_byte(adj_q[3:1], 2'(bld_q >> 2));
    nib   = bld_q[1] ? seed[3:0] : seed[7:4];
    entry = {1'b0, nib, 3'b000} + {3'b000, nib, 1'b0};
    if (bld_q[0]) entry = entry + ODD_OFFSET;
    entry = entry - {4'h0, adj_q[7:4]};
    dst   = adj_q[0] ? IdxW'(HopDepth - 1) - bld_q : bld_q;
  end

  assign stat_o.build_last = (bld_q == IdxW'(HopDepth - 1));

  // pulse width: channel/2 toward zero, plus center
  always_comb begin
    widx  = cmd_i.byte_idx - BYTE_WIDTH;
    sel   = ch_q[widx[3:1]];
    rnd   = sel + {{(CHAN_W-1){1'b0}}, sel[CHAN_W-1]};
    half  = {rnd[CHAN_W-1], rnd[CHAN_W-1:1]};
    width = {{(16-CHAN_W){half[CHAN_W-1]}}, half} + {4'h0, center_i};
  end

  always_comb begin
    unique case (cmd_i.byte_idx)
      BYTE_HDR:  byte_d = bind_i ? HDR_BIND : HDR_NORM;
      BYTE_ID3:  byte_d = adj_q;
      BYTE_ID2:  byte_d = tx_id_i[23:16];
      BYTE_ID1:  byte_d = tx_id_i[15:8];
      BYTE_ID0:  byte_d = tx_id_i[7:0];
      BYTE_CHAN: byte_d = bind_i ? BIND_CHAN : hop_q[pos_q];
      default:   byte_d = widx[0] ? width[15:8] : width[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HopDepth; k++) hop_q[k] <= '0;
      pos_q <= '0;
      bld_q <= '0;
      adj_q <= '0;
    end else begin
      if (cmd_i.init_start) begin
        adj_q <= adj_d;
        bld_q <= '0;
        pos_q <= '0;
      end
      if (cmd_i.build_step) begin
        hop_q[dst] <= entry;
        bld_q      <= bld_q + 1'b1;
      end
      if (cmd_i.hop_advance) pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_start) begin
      for (int k = 0; k < CHAN_NUM; k++) ch_q[k] <= chan_i[k];
    end
    if (cmd_i.out_load) begin
      out_byte_q <= byte_d;
      out_cw_q   <= (cmd_i.byte_idx == BYTE_CHAN);
      out_last_q <= (cmd_i.byte_idx == BYTE_CHAN);
      // antenna toggles unless the advanced position wraps to zero
      out_ant_q  <= (cmd_i.byte_idx == BYTE_CHAN) && (pos_q != IdxW'(HopDepth - 1));
    end
  end

  assign out_byte_o = out_byte_q;
  assign out_cw_o   = out_cw_q;
  assign out_ant_o  = out_ant_q;
  assign out_last_o = out_last_q;

`ifndef SYNTHESIS
  a_ant_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (!out_ant_q || out_last_q) && (out_last_q == out_cw_q))
    else $error("antenna or channel-write flag off the last item");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hop_advance && !cmd_i.init_start |=> pos_q == IdxW'($past(pos_q) + 1'b1))
    else $error("hop position did not advance");

  a_build_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.build_step |-> !cmd_i.out_load && !cmd_i.hop_advance)
    else $error("table build overlaps frame emission");
`endif

endmodule

FILE: rtl/core/rc_hop_frame_builder_unit.sv
// RC hop frame builder.
// Channels: configuration write port (cfg_we_i/cfg_idx_i/cfg_data_i, taken at once,
// index 0 tx_id, 1 bind_mode, 2 pulse_center), an input item channel and a result
// item channel, both valid/ready.
// A kind 0 item (init) adjusts the top id byte and rebuilds the 16-entry hop table,
// one entry a cycle: the block accepts no new item until the table is built and gives no result.
// A kind 1 item (frame) gives 22 result items: header, four id bytes, eight
// little-endian pulse widths, then the channel-register write flagged last.
// After acceptance the controller enters its emit state and then loads the header byte
// into the output register; with the receiver always ready the output register takes
// one byte a cycle. A new item is accepted while the last byte still waits there.
// When the receiver stalls, the output register holds and emission pauses.
// Reset clears the hop table, hop position and id byte to zero, tx_id and bind_mode
// to zero and pulse_center to 1500; no result is pending after reset.
// Depends on rchfb_pkg, rchfb_ctrl, rchfb_dp.
module rc_hop_frame_builder_unit
  import rchfb_pkg::*;
#(
  parameter int unsigned HopDepth = HOP_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_kind_i,
  input  logic signed [11:0] in_channel_0_i,
  input  logic signed [11:0] in_channel_1_i,
  input  logic signed [11:0] in_channel_2_i,
  input  logic signed [11:0] in_channel_3_i,
  input  logic signed [11:0] in_channel_4_i,
  input  logic signed [11:0] in_channel_5_i,
  input  logic signed [11:0] in_channel_6_i,
  input  logic signed [11:0] in_channel_7_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_out_byte_o,
  output logic              out_is_channel_write_o,
  output logic              out_antenna_switch_o,
  output logic              out_last_o
);

  logic [31:0] tx_id_q;
  logic        bind_q;
  logic [11:0] center_q;

  rchfb_cmd_t  cmd;
  rchfb_stat_t stat;
  logic signed [CHAN_W-1:0] chans [CHAN_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_id_q  <= '0;
      bind_q   <= 1'b0;
      center_q <= CENTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TX_ID:  tx_id_q  <= cfg_data_i;
        CFG_BIND:   bind_q   <= cfg_data_i[0];
        CFG_CENTER: center_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign chans[0] = in_channel_0_i;
  assign chans[1] = in_channel_1_i;
  assign chans[2] = in_channel_2_i;
  assign chans[3] = in_channel_3_i;
  assign chans[4] = in_channel_4_i;
  assign chans[5] = in_channel_5_i;
  assign chans[6] = in_channel_6_i;
  assign chans[7] = in_channel_7_i;

  rchfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_kind_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rchfb_dp #(
    .HopDepth (HopDepth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .tx_id_i    (tx_id_q),
    .bind_i     (bind_q),
    .center_i   (center_q),
    .chan_i     (chans),
    .out_byte_o (out_out_byte_o),
    .out_cw_o   (out_is_channel_write_o),
    .out_ant_o  (out_antenna_switch_o),
    .out_last_o (out_last_o)
  );

endmodule
